// ===== sv/srt_subtitle_parser_macros.svh =====
// Assertion macros for the SRT subtitle parser.
// Needs clk_i and rst_ni in the scope of each use; empty when SYNTH is set.
`ifndef SRT_SUBTITLE_PARSER_MACROS_SVH
`define SRT_SUBTITLE_PARSER_MACROS_SVH
`ifndef SYNTH
`define SRTP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("srtp: forbidden condition");
`define SRTP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srtp: implication failed");
`else
`define SRTP_ASSERT_NEVER(lbl, cond)
`define SRTP_ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

// ===== sv/srtp_pkg.sv =====
// Shared types and constants of the SRT subtitle parser.
// Used by the front, queue, back and top level; depends on nothing.
`timescale 1ns / 1ps
package srtp_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    KIND_TIMES = 3'd0,
    KIND_TEXT  = 3'd1,
    KIND_BREAK = 3'd2,
    KIND_END   = 3'd3,
    KIND_STOP  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'd0,
    PH_INDEX = 3'd1,
    PH_TIMES = 3'd2,
    PH_TEXT  = 3'd3,
    PH_BAD   = 3'd4
  } phase_e;

  // All results caused by one input byte
  typedef struct packed {
    logic [2:0]       count;
    kind_e [3:0]      kind;
    logic [3:0][7:0]  ch;
    logic [3:0]       keep;
    logic [31:0]      begin_ms;
    logic [31:0]      finish_ms;
  } step_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Weight of each timestamp token in milliseconds
  function automatic logic [21:0] token_weight(input logic [4:0] pos);
    logic [21:0] w;
    unique case (pos)
      5'd0, 5'd10: w = 22'd3600000;
      5'd2, 5'd12: w = 22'd60000;
      5'd4, 5'd14: w = 22'd1000;
      5'd6, 5'd16: w = 22'd1;
      default:     w = 22'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/srtp_front.sv =====
// Front part of the SRT subtitle parser: accepts bytes, runs the parse state
// and packs each byte's results into one step request. Depends on srtp_pkg.
`timescale 1ns / 1ps
module srtp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_final_i,
  input  srtp_pkg::q_stat_t   q_stat_i,
  output logic                in_ready_o,
  output logic                push_o,
  output srtp_pkg::step_t     step_o
);

  typedef struct packed {
    logic act;
    logic ovf;
    logic dig;
    logic neg;
  } nflags_t;

  typedef struct packed {
    logic [1:0]  res;
    logic [31:0] acc;
    nflags_t     fl;
  } feed_t;

  localparam logic [1:0] FeedTaken = 2'd0;
  localparam logic [1:0] FeedDone  = 2'd1;
  localparam logic [1:0] FeedFail  = 2'd2;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13 && c != 8'd10);
  endfunction

  function automatic logic is_int_tok(input logic [4:0] p);
    return (p[0] == 1'b0) && (p != 5'd8) && (p < 5'd17);
  endfunction

  // One byte into the decimal integer scanner
  function automatic feed_t int_feed(input logic [7:0] c, input logic [31:0] acc,
                                     input nflags_t fl);
    feed_t       f;
    logic        dig;
    logic        go;
    logic [35:0] nxt;
    logic [35:0] lim;
    f.res = FeedTaken;
    f.acc = acc;
    f.fl  = fl;
    dig   = (c >= 8'd48) && (c <= 8'd57);
    go    = 1'b0;
    nxt   = '0;
    lim   = '0;
    if (!fl.act) begin
      if (is_ws(c)) begin
        go = 1'b0;
      end else if (c == 8'd43 || c == 8'd45) begin
        f.fl     = '0;
        f.fl.act = 1'b1;
        f.fl.neg = (c == 8'd45);
      end else if (!dig) begin
        f.res = FeedFail;
      end else begin
        f.fl     = '0;
        f.fl.act = 1'b1;
        go       = 1'b1;
      end
    end else if (!dig) begin
      f.res = (!fl.dig || fl.ovf) ? FeedFail : FeedDone;
    end else begin
      go = 1'b1;
    end
    if (go) begin
      if (!f.fl.ovf) begin
        nxt = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {28'd0, c - 8'd48};
        lim = f.fl.neg ? 36'h080000000 : 36'h07FFFFFFF;
        if (nxt > lim) f.fl.ovf = 1'b1;
        else f.acc = nxt[31:0];
      end
      f.fl.dig = 1'b1;
    end
    return f;
  endfunction

  srtp_pkg::phase_e phase_q, phase_d;
  logic [4:0]  tok_q, tok_d;
  logic [31:0] acc_q, acc_d;
  nflags_t     fl_q, fl_d;
  logic [31:0] beg_q, beg_d;
  logic [31:0] fin_q, fin_d;
  logic [1:0]  held_q, held_d;
  logic        lnz_q, lnz_d;
  logic        has_q, has_d;
  logic        stop_q, stop_d;

  logic        accept;
  logic        lf;
  logic        ws;
  logic        final_ok;
  logic [31:0] value;
  logic [53:0] prod_full;
  logic [31:0] prod;
  feed_t       fr;
  srtp_pkg::step_t st;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign lf         = (in_byte_i == 8'd10);
  assign ws         = is_ws(in_byte_i);
  assign final_ok   = fl_q.act && fl_q.dig && !fl_q.ovf;

  // Weighted token value; only ever uses the stored number and position
  assign value     = fl_q.neg ? (32'd0 - acc_q) : acc_q;
  assign prod_full = value * srtp_pkg::token_weight(tok_q);
  assign prod      = prod_full[31:0];

  // Parse one byte and collect its results
  always_comb begin
    phase_d = phase_q;
    tok_d   = tok_q;
    acc_d   = acc_q;
    fl_d    = fl_q;
    beg_d   = beg_q;
    fin_d   = fin_q;
    held_d  = held_q;
    lnz_d   = lnz_q;
    has_d   = has_q;
    stop_d  = stop_q;
    fr      = '0;
    st      = '0;
    if (stop_q) begin
      st.kind[st.count[1:0]] = srtp_pkg::KIND_STOP;
      st.count = st.count + 3'd1;
    end else if (in_final_i && !lf) begin
      if (phase_q == srtp_pkg::PH_TEXT) begin
        st.kind[st.count[1:0]] = srtp_pkg::KIND_END;
        st.count = st.count + 3'd1;
      end
      stop_d = 1'b1;
      st.kind[st.count[1:0]] = srtp_pkg::KIND_STOP;
      st.count = st.count + 3'd1;
    end else begin
      unique case (phase_q)
        srtp_pkg::PH_SKIP: begin
          if (!lf) begin
            phase_d = srtp_pkg::PH_INDEX;
            tok_d   = '0;
            fr      = int_feed(in_byte_i, 32'd0, '0);
            acc_d   = fr.acc;
            fl_d    = fr.fl;
            if (fr.res == FeedFail) phase_d = srtp_pkg::PH_BAD;
          end
        end
        srtp_pkg::PH_INDEX: begin
          if (lf) begin
            if (tok_q != 5'd0 || final_ok) begin
              phase_d = srtp_pkg::PH_TIMES;
              tok_d   = '0;
              acc_d   = '0;
              fl_d    = '0;
              beg_d   = '0;
              fin_d   = '0;
            end else begin
              stop_d = 1'b1;
              st.kind[st.count[1:0]] = srtp_pkg::KIND_STOP;
              st.count = st.count + 3'd1;
            end
          end else if (tok_q == 5'd0) begin
            fr    = int_feed(in_byte_i, acc_q, fl_q);
            acc_d = fr.acc;
            fl_d  = fr.fl;
            if (fr.res == FeedFail) phase_d = srtp_pkg::PH_BAD;
            else if (fr.res == FeedDone) tok_d = 5'd1;
          end
        end
        srtp_pkg::PH_TIMES: begin
          if (lf) begin
            if (tok_q == 5'd16 && final_ok) begin
              fin_d = fin_q + prod;
              tok_d = 5'd17;
              acc_d = '0;
              fl_d  = '0;
            end
            if (tok_d >= 5'd17) begin
              st.kind[st.count[1:0]] = srtp_pkg::KIND_TIMES;
              st.begin_ms  = beg_d;
              st.finish_ms = fin_d;
              st.count = st.count + 3'd1;
              phase_d = srtp_pkg::PH_TEXT;
              has_d   = 1'b0;
              lnz_d   = 1'b0;
              held_d  = '0;
            end else begin
              stop_d = 1'b1;
              st.kind[st.count[1:0]] = srtp_pkg::KIND_STOP;
              st.count = st.count + 3'd1;
            end
          end else if (tok_q < 5'd17) begin
            if (is_int_tok(tok_q)) begin
              fr    = int_feed(in_byte_i, acc_q, fl_q);
              acc_d = fr.acc;
              fl_d  = fr.fl;
              if (fr.res == FeedFail) begin
                phase_d = srtp_pkg::PH_BAD;
              end else if (fr.res == FeedDone) begin
                // Close the token, then count the separator
                if (tok_q < 5'd8) beg_d = beg_q + prod;
                else fin_d = fin_q + prod;
                acc_d = '0;
                fl_d  = '0;
                tok_d = tok_q + 5'd1;
                if (tok_d < 5'd17 && !ws) tok_d = tok_d + 5'd1;
              end
            end else if (!ws) begin
              tok_d = tok_q + 5'd1;
            end
          end
        end
        srtp_pkg::PH_TEXT: begin
          if (lf) begin
            if (!lnz_q) begin
              if (has_q) begin
                st.kind[st.count[1:0]] = srtp_pkg::KIND_END;
                st.keep[st.count[1:0]] = 1'b1;
                st.count = st.count + 3'd1;
                phase_d = srtp_pkg::PH_SKIP;
              end else begin
                st.kind[st.count[1:0]] = srtp_pkg::KIND_END;
                st.count = st.count + 3'd1;
                stop_d = 1'b1;
                st.kind[st.count[1:0]] = srtp_pkg::KIND_STOP;
                st.count = st.count + 3'd1;
              end
            end else begin
              // A lone backslash is flushed, an exact backslash-n is dropped
              if (held_q == 2'd1) begin
                st.kind[st.count[1:0]] = srtp_pkg::KIND_TEXT;
                st.ch[st.count[1:0]]   = 8'd92;
                st.count = st.count + 3'd1;
              end
              held_d = '0;
              st.kind[st.count[1:0]] = srtp_pkg::KIND_BREAK;
              st.count = st.count + 3'd1;
              has_d = 1'b1;
              lnz_d = 1'b0;
            end
          end else if (!lnz_q) begin
            lnz_d = 1'b1;
            if (in_byte_i == 8'd92) begin
              held_d = 2'd1;
            end else begin
              st.kind[st.count[1:0]] = srtp_pkg::KIND_TEXT;
              st.ch[st.count[1:0]]   = in_byte_i;
              st.count = st.count + 3'd1;
            end
          end else if (held_q == 2'd1 && in_byte_i == 8'd110) begin
            held_d = 2'd2;
          end else begin
            // Flush held bytes, then pass this one
            if (held_q != 2'd0) begin
              st.kind[st.count[1:0]] = srtp_pkg::KIND_TEXT;
              st.ch[st.count[1:0]]   = 8'd92;
              st.count = st.count + 3'd1;
            end
            if (held_q == 2'd2) begin
              st.kind[st.count[1:0]] = srtp_pkg::KIND_TEXT;
              st.ch[st.count[1:0]]   = 8'd110;
              st.count = st.count + 3'd1;
            end
            held_d = '0;
            st.kind[st.count[1:0]] = srtp_pkg::KIND_TEXT;
            st.ch[st.count[1:0]]   = in_byte_i;
            st.count = st.count + 3'd1;
          end
        end
        default: begin
          if (lf) begin
            stop_d = 1'b1;
            st.kind[st.count[1:0]] = srtp_pkg::KIND_STOP;
            st.count = st.count + 3'd1;
          end
        end
      endcase
      // End of stream closes an open record
      if (in_final_i && !stop_d) begin
        if (phase_d == srtp_pkg::PH_TEXT) begin
          st.kind[st.count[1:0]] = srtp_pkg::KIND_END;
          st.keep[st.count[1:0]] = has_d;
          st.count = st.count + 3'd1;
        end
        stop_d = 1'b1;
        st.kind[st.count[1:0]] = srtp_pkg::KIND_STOP;
        st.count = st.count + 3'd1;
      end
    end
  end

  assign push_o = accept && (st.count != 3'd0);
  assign step_o = st;

  // Hold parse state, advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= srtp_pkg::PH_SKIP;
      tok_q   <= '0;
      acc_q   <= '0;
      fl_q    <= '0;
      beg_q   <= '0;
      fin_q   <= '0;
      held_q  <= '0;
      lnz_q   <= 1'b0;
      has_q   <= 1'b0;
      stop_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      tok_q   <= tok_d;
      acc_q   <= acc_d;
      fl_q    <= fl_d;
      beg_q   <= beg_d;
      fin_q   <= fin_d;
      held_q  <= held_d;
      lnz_q   <= lnz_d;
      has_q   <= has_d;
      stop_q  <= stop_d;
    end
  end

endmodule

// ===== sv/srtp_queue.sv =====
// Step request queue between the front and back parts.
// Depends on srtp_pkg for the step type.
`timescale 1ns / 1ps
module srtp_queue #(
  parameter int unsigned Depth = srtp_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  srtp_pkg::step_t   wdata_i,
  input  logic              pop_i,
  output srtp_pkg::step_t   rdata_o,
  output srtp_pkg::q_stat_t stat_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  srtp_pkg::step_t mem [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign stat_o.full  = (cnt_q == (AW+1)'(Depth));
  assign stat_o.valid = (cnt_q != '0);
  assign rdata_o      = mem[rd_q];

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= wdata_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= bump(wr_q);
      if (pop_i) rd_q <= bump(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

endmodule

// ===== sv/srtp_back.sv =====
// Back part of the SRT subtitle parser: unpacks step requests into single
// results on the output stream. Depends on srtp_pkg.
`timescale 1ns / 1ps
module srtp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srtp_pkg::q_stat_t   q_stat_i,
  input  srtp_pkg::step_t     q_data_i,
  output logic                pop_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output srtp_pkg::kind_e     kind_o,
  output logic [7:0]          text_o,
  output logic [31:0]         begin_o,
  output logic [31:0]         finish_o,
  output logic                keep_o,
  output logic                last_o
);

  srtp_pkg::step_t cur_q;
  logic            vld_q;
  logic [1:0]      idx_q;
  logic            take;
  logic            is_last;

  assign is_last = ({1'b0, idx_q} == (cur_q.count - 3'd1));
  assign take    = vld_q && out_ready_i;
  assign pop_o   = q_stat_i.valid && (!vld_q || (take && is_last));

  // Hold the current step, advance through its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (take) begin
      if (is_last) vld_q <= 1'b0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_data_i;
  end

  assign out_valid_o = vld_q;
  assign kind_o      = cur_q.kind[idx_q];
  assign text_o      = (cur_q.kind[idx_q] == srtp_pkg::KIND_TEXT) ? cur_q.ch[idx_q] : 8'd0;
  assign begin_o     = (cur_q.kind[idx_q] == srtp_pkg::KIND_TIMES) ? cur_q.begin_ms : 32'd0;
  assign finish_o    = (cur_q.kind[idx_q] == srtp_pkg::KIND_TIMES) ? cur_q.finish_ms : 32'd0;
  assign keep_o      = cur_q.keep[idx_q];
  assign last_o      = is_last;

endmodule

// ===== sv/srt_subtitle_parser.sv =====
// SRT subtitle parser: one byte in per cycle, results out one per cycle, while the receiver is ready.
// Each step request passes through the queue into the back part's register before its first result.
// Throughput: one byte per cycle while each byte causes at most one result and the
// receiver is ready; a byte with several results holds the output stream until all are taken.
// Reset (rst_ni low, asynchronous) clears parse state, queue and output.
`timescale 1ns / 1ps
`include "srt_subtitle_parser_macros.svh"
module srt_subtitle_parser #(
  parameter int unsigned QDepth = srtp_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [7:0] text_byte, [39:8] begin_ms,
                                      // [71:40] finish_ms, [72] keep, zero pad
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last_of_step
);

  srtp_pkg::q_stat_t q_stat;
  srtp_pkg::step_t   push_data, q_data;
  srtp_pkg::kind_e   kind;
  logic              push, pop;
  logic [7:0]        text;
  logic [31:0]       begin_ms, finish_ms;
  logic              keep;

  srtp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .q_stat_i   (q_stat),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .step_o     (push_data)
  );

  srtp_queue #(.Depth(QDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .pop_i   (pop),
    .rdata_o (q_data),
    .stat_o  (q_stat)
  );

  srtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .kind_o      (kind),
    .text_o      (text),
    .begin_o     (begin_ms),
    .finish_o    (finish_ms),
    .keep_o      (keep),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {7'd0, keep, finish_ms, begin_ms, text};

  // Queue must not be written when full, nor popped when empty
  `SRTP_ASSERT_NEVER(a_no_overflow, push && q_stat.full)
  `SRTP_ASSERT_NEVER(a_no_underflow, pop && !q_stat.valid)
  // Only defined result kinds leave the block
  `SRTP_ASSERT_NEVER(a_kind_range, m_axis_tvalid && (m_axis_tuser > 3'd4))
  // Text byte is zero on every result that is not text
  `SRTP_ASSERT_IMPLIES(a_text_zero, m_axis_tvalid && (kind != srtp_pkg::KIND_TEXT),
                       m_axis_tdata[7:0] == 8'd0)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the SRT subtitle parser stream block.
// Depends on srtp_pkg and srt_subtitle_parser; predicts every result per input byte.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [3:0] NumNeg = 4'd1;
  localparam logic [3:0] NumDig = 4'd2;
  localparam logic [3:0] NumOvf = 4'd4;
  localparam logic [3:0] NumAct = 4'd8;
  localparam int         TokDone = 17;
  localparam int         FeedMore = 0;
  localparam int         FeedDone = 1;
  localparam int         FeedFail = 2;

  typedef struct {
    srtp_pkg::kind_e kind;
    logic [7:0]      ch;
    logic [31:0]     begin_ms;
    logic [31:0]     finish_ms;
    logic            keep;
    logic            last;
  } srt_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  srt_subtitle_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Predictor state
  srtp_pkg::phase_e prs_phase;
  int          prs_tok;
  logic [31:0] prs_num;
  logic [3:0]  prs_flags;
  logic [31:0] prs_begin;
  logic [31:0] prs_finish;
  logic [7:0]  prs_held [2];
  int          prs_held_n;
  logic        prs_line_open;
  logic        prs_has_text;
  logic        prs_stopped;

  srt_result_t step_res[$];
  srt_result_t expected_results[$];
  int          errors = 0;
  int          bytes_sent = 0;
  bit          sender_busy_run = 0;
  bit          receiver_busy_run = 0;
  int          receiver_hold = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("srt_subtitle_parser: mismatch");
    $finish;
  end

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13 && c != 8'd10);
  endfunction

  function automatic void add_result(srtp_pkg::kind_e k, logic [7:0] ch, logic [31:0] b,
                                     logic [31:0] f, logic keep);
    srt_result_t r;
    if (step_res.size() >= 4) return;
    r.kind = k;
    r.ch = ch;
    r.begin_ms = b;
    r.finish_ms = f;
    r.keep = keep;
    r.last = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void clear_number();
    prs_num = '0;
    prs_flags = '0;
  endfunction

  // Feed one byte into the integer scanner
  function automatic int scan_int(logic [7:0] c);
    bit          dig;
    logic [31:0] d;
    logic [31:0] lim;
    dig = c >= 8'd48 && c <= 8'd57;
    if (!(prs_flags & NumAct)) begin
      if (is_space(c)) return FeedMore;
      if (c == 8'd43 || c == 8'd45) begin
        prs_flags = NumAct | ((c == 8'd45) ? NumNeg : 4'd0);
        return FeedMore;
      end
      if (!dig) return FeedFail;
      prs_flags = NumAct;
    end else if (!dig) begin
      if (!(prs_flags & NumDig) || (prs_flags & NumOvf)) return FeedFail;
      return FeedDone;
    end
    if (!(prs_flags & NumOvf)) begin
      d = 32'(c - 8'd48);
      lim = (prs_flags & NumNeg) ? 32'h8000_0000 : 32'h7fff_ffff;
      if (prs_num > (lim - d) / 10) prs_flags |= NumOvf;
      else prs_num = prs_num * 10 + d;
    end
    prs_flags |= NumDig;
    return FeedMore;
  endfunction

  function automatic bit number_ok();
    return (prs_flags & NumAct) != 0 && (prs_flags & NumDig) != 0 && (prs_flags & NumOvf) == 0;
  endfunction

  function automatic logic [31:0] ms_weight(int p);
    case (p)
      0, 10:   return 32'd3600000;
      2, 12:   return 32'd60000;
      4, 14:   return 32'd1000;
      6, 16:   return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

  // Add the finished number into the begin or finish time
  function automatic void add_time_token();
    logic [31:0] v;
    if (prs_tok > 16) return;
    v = (prs_flags & NumNeg) ? 32'd0 - prs_num : prs_num;
    if (prs_tok < 8) prs_begin += v * ms_weight(prs_tok);
    else prs_finish += v * ms_weight(prs_tok);
    prs_tok++;
    clear_number();
  endfunction

  function automatic void timestamp_byte(logic [7:0] c);
    int r;
    if (prs_tok >= TokDone) return;
    if ((prs_tok % 2) == 0 && prs_tok != 8) begin
      r = scan_int(c);
      if (r == FeedFail) begin
        prs_phase = srtp_pkg::PH_BAD;
        return;
      end
      if (r == FeedMore) return;
      add_time_token();
      if (prs_tok >= TokDone) return;
    end
    if (!is_space(c)) prs_tok++;
  endfunction

  function automatic void fail_stream();
    if (prs_phase == srtp_pkg::PH_TEXT) add_result(srtp_pkg::KIND_END, 0, 0, 0, 1'b0);
    prs_stopped = 1'b1;
    add_result(srtp_pkg::KIND_STOP, 0, 0, 0, 1'b0);
  endfunction

  function automatic void flush_held();
    for (int k = 0; k < prs_held_n && k < 2; k++) begin
      add_result(srtp_pkg::KIND_TEXT, prs_held[k], 0, 0, 1'b0);
    end
    prs_held_n = 0;
  endfunction

  // Text line byte, with the backslash-n hold back
  function automatic void text_byte(logic [7:0] c);
    if (c == 8'd10) begin
      if (!prs_line_open) begin
        if (prs_has_text) begin
          add_result(srtp_pkg::KIND_END, 0, 0, 0, 1'b1);
          prs_phase = srtp_pkg::PH_SKIP;
        end else begin
          fail_stream();
        end
        return;
      end
      if (prs_held_n >= 2) prs_held_n = 0;
      else flush_held();
      add_result(srtp_pkg::KIND_BREAK, 0, 0, 0, 1'b0);
      prs_has_text = 1'b1;
      prs_line_open = 1'b0;
      return;
    end
    if (!prs_line_open) begin
      prs_line_open = 1'b1;
      if (c == 8'd92) begin
        prs_held[0] = c;
        prs_held_n = 1;
        return;
      end
    end else if (prs_held_n == 1 && c == 8'd110) begin
      prs_held[1] = c;
      prs_held_n = 2;
      return;
    end else begin
      flush_held();
    end
    add_result(srtp_pkg::KIND_TEXT, c, 0, 0, 1'b0);
  endfunction

  // Work out all results of one accepted byte
  function automatic void predict_parse(logic [7:0] c, logic fin);
    bit lf;
    int r;
    lf = c == 8'd10;
    step_res.delete();
    if (prs_stopped) begin
      add_result(srtp_pkg::KIND_STOP, 0, 0, 0, 1'b0);
    end else if (fin && !lf) begin
      fail_stream();
    end else begin
      case (prs_phase)
        srtp_pkg::PH_SKIP: begin
          if (!lf) begin
            prs_phase = srtp_pkg::PH_INDEX;
            prs_tok = 0;
            clear_number();
            if (scan_int(c) == FeedFail) prs_phase = srtp_pkg::PH_BAD;
          end
        end
        srtp_pkg::PH_INDEX: begin
          if (lf) begin
            if (prs_tok != 0 || number_ok()) begin
              prs_phase = srtp_pkg::PH_TIMES;
              prs_tok = 0;
              clear_number();
              prs_begin = '0;
              prs_finish = '0;
            end else begin
              fail_stream();
            end
          end else if (prs_tok == 0) begin
            r = scan_int(c);
            if (r == FeedFail) prs_phase = srtp_pkg::PH_BAD;
            else if (r == FeedDone) prs_tok = 1;
          end
        end
        srtp_pkg::PH_TIMES: begin
          if (lf) begin
            if (prs_tok == 16 && number_ok()) add_time_token();
            if (prs_tok >= TokDone) begin
              add_result(srtp_pkg::KIND_TIMES, 0, prs_begin, prs_finish, 1'b0);
              prs_phase = srtp_pkg::PH_TEXT;
              prs_has_text = 1'b0;
              prs_line_open = 1'b0;
              prs_held_n = 0;
            end else begin
              fail_stream();
            end
          end else begin
            timestamp_byte(c);
          end
        end
        srtp_pkg::PH_TEXT: text_byte(c);
        default: if (lf) fail_stream();
      endcase
      if (fin && !prs_stopped) begin
        if (prs_phase == srtp_pkg::PH_TEXT) begin
          add_result(srtp_pkg::KIND_END, 0, 0, 0, prs_has_text);
        end
        prs_stopped = 1'b1;
        add_result(srtp_pkg::KIND_STOP, 0, 0, 0, 1'b0);
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_results.insert(expected_results.size(), step_res[i]);
  endfunction

  // Send one byte request; called at a clock edge
  task automatic send_byte(input logic [7:0] c, input logic fin = 1'b0);
    int gap;
    gap = sender_busy_run ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_parse(c, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic string pad_space();
    case ($urandom_range(0, 7))
      0:       return " ";
      1:       return "\t";
      2:       return "\r";
      3:       return " \v\f ";
      default: return "";
    endcase
  endfunction

  function automatic string time_num(int unsigned width);
    int v;
    string s;
    case ($urandom_range(0, 15))
      0:       v = 2147483647;
      1:       v = int'(32'h8000_0000);
      2:       v = -$urandom_range(0, 99);
      3:       v = $urandom_range(0, 2000000);
      default: v = $urandom_range(0, width);
    endcase
    s = $sformatf("%0d", v);
    if (v >= 0 && $urandom_range(0, 5) == 0) s = {"+", s};
    else if (v >= 0 && $urandom_range(0, 3) == 0) s = {"0", s};
    return s;
  endfunction

  function automatic string stamp_line();
    string sep[4] = '{":", ",", ".", "x"};
    string arrow;
    string s;
    if ($urandom_range(0, 3) == 0) arrow = "9";
    else arrow = ">";
    s = {pad_space(), time_num(99), pad_space(), sep[$urandom_range(0, 3)],
         pad_space(), time_num(59), pad_space(), sep[$urandom_range(0, 3)],
         pad_space(), time_num(59), pad_space(), sep[$urandom_range(0, 3)],
         pad_space(), time_num(999), pad_space(), "-", pad_space(), "-",
         pad_space(), arrow,
         pad_space(), time_num(99), pad_space(), sep[$urandom_range(0, 3)],
         pad_space(), time_num(59), pad_space(), sep[$urandom_range(0, 3)],
         pad_space(), time_num(59), pad_space(), sep[$urandom_range(0, 3)],
         pad_space(), time_num(999)};
    if ($urandom_range(0, 3) == 0) s = {s, " X1 extra"};
    return {s, pad_space(), "\n"};
  endfunction

  // One text line of random bytes, with backslash variants
  task automatic send_text_line();
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: send_text("\\n");
      1: send_text("\\");
      2: send_text("\\nx");
      3: send_text("\\q");
      default: begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255)); while (c == 8'd10);
          send_byte(c);
        end
      end
    endcase
    send_byte(8'd10);
  endtask

  task automatic send_header();
    string tail;
    repeat ($urandom_range(0, 2)) send_byte(8'd10);
    if ($urandom_range(0, 3) == 0) tail = " idx";
    else tail = "";
    send_text({pad_space(), time_num(9999), pad_space(), tail, "\n"});
    send_text(stamp_line());
  endtask

  task automatic send_record();
    send_header();
    repeat ($urandom_range(1, 4)) send_text_line();
    send_byte(8'd10);
  endtask

  // Known records with field extremes and backslash cases
  task automatic test_directed();
    send_text("\n1\n00:00:01,000 --> 00:00:02,500\nHi\n\n");
    send_text("+0\r\n2147483647:0:0:0-->-2147483648:0:0:0\n\\n\n\\");
    send_byte(8'hff);
    send_byte(8'h00);
    send_text("\n\n");
    wait_drained();
  endtask

  // Well-formed records with random content and idling
  task automatic test_random_records();
    int rec = 0;
    while (bytes_sent < 440) begin
      if (rec % 7 == 3) sender_busy_run = 1;
      if (rec % 7 == 5) begin
        sender_busy_run = 0;
        receiver_busy_run = !receiver_busy_run;
      end
      if (rec == 4) receiver_hold = 200;
      if (rec == 9) wait_drained();
      send_record();
      rec++;
    end
    sender_busy_run = 0;
    receiver_busy_run = 0;
  endtask

  // One way of stopping the parser, then bytes after the stop
  task automatic test_stop();
    case ($urandom_range(0, 5))
      0: send_text("abc\n");
      1: send_text("99999999999\n");
      2: begin
        send_header();
        send_byte(8'd10);
      end
      3: send_text("1\n00:00:01\n");
      4: begin
        send_header();
        send_text_line();
        send_byte("x", 1'b1);
      end
      default: begin
        send_header();
        send_text_line();
        send_byte(8'd10, 1'b1);
      end
    endcase
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Receiver: random stalls, busy stretches and one long hold
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (receiver_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (receiver_hold) @(posedge clk_i);
        receiver_hold = 0;
      end
      gap = receiver_busy_run ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    srt_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: kind %0d data %h", $time,
                 m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tuser !== e.kind || m_axis_tdata[7:0] !== e.ch ||
            m_axis_tdata[39:8] !== e.begin_ms || m_axis_tdata[71:40] !== e.finish_ms ||
            m_axis_tdata[72] !== e.keep || m_axis_tlast !== e.last) begin
          $display("%0t: expected kind %0d ch %h begin %h finish %h keep %b last %b", $time,
                   e.kind, e.ch, e.begin_ms, e.finish_ms, e.keep, e.last);
          $display("%0t: actual   kind %0d ch %h begin %h finish %h keep %b last %b", $time,
                   m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                   m_axis_tdata[71:40], m_axis_tdata[72], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    prs_phase = srtp_pkg::PH_SKIP;
    prs_tok = 0;
    clear_number();
    prs_begin = '0;
    prs_finish = '0;
    prs_held_n = 0;
    prs_line_open = 1'b0;
    prs_has_text = 1'b0;
    prs_stopped = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_records();
    test_stop();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("srt_subtitle_parser: match");
    end else begin
      $display("srt_subtitle_parser: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/srtp_pkg.sv
sv/srtp_front.sv
sv/srtp_queue.sv
sv/srtp_back.sv
sv/srt_subtitle_parser.sv
dv/tb_top.sv
